@@ src/ssm_pkg.sv @@
// Shared types, constants and the lowercase font for the scrolling seven-segment mux.
// No dependencies; every other file in src but ssm_ram refers to this package by scoped names.
package ssm_pkg;

   localparam int MESSAGE_DEPTH  = 64;
   localparam int DIGIT_COUNT    = 4;
   localparam int DIGIT_WIDTH    = 2;
   localparam int CHAR_WIDTH     = 8;
   localparam int GLYPH_WIDTH    = 7;
   localparam int LENGTH_WIDTH   = 7;
   localparam int INDEX_WIDTH    = 6;
   // holds message length plus two trailing blanks for any 7-bit length
   localparam int POSITION_WIDTH = 8;
   localparam int LETTER_COUNT   = 26;

   localparam logic [CHAR_WIDTH-1:0] FIRST_LETTER = 8'h61;

   typedef enum logic [1:0] {
      REQ_WRITE  = 2'd0,
      REQ_SCAN   = 2'd1,
      REQ_SCROLL = 2'd2
   } req_code_type;

   typedef struct packed {
      logic [1:0]             req_type;
      logic [INDEX_WIDTH-1:0] write_index;
      logic [CHAR_WIDTH-1:0]  write_char;
   } req_item_type;

   typedef struct packed {
      logic [GLYPH_WIDTH-1:0] segments_n;
      logic [DIGIT_COUNT-1:0] digit_enable;
   } rsp_item_type;

   // transaction held between the input stage and the execute stage
   typedef struct packed {
      logic       valid;
      logic [1:0] req_type;
      logic       in_range;
   } stage_item_type;

   localparam logic [GLYPH_WIDTH-1:0] FONT_LOWER [LETTER_COUNT] = '{
      7'h77, 7'h7C, 7'h58, 7'h5E, 7'h79, 7'h71, 7'h6F, 7'h76, 7'h06, 7'h0E,
      7'h70, 7'h38, 7'h55, 7'h54, 7'h5C, 7'h73, 7'h67, 7'h50, 7'h6D, 7'h78,
      7'h3E, 7'h1C, 7'h1D, 7'h76, 7'h66, 7'h5B
   };

   function automatic logic [GLYPH_WIDTH-1:0] glyph_of(input logic [CHAR_WIDTH-1:0] code);
      logic [CHAR_WIDTH-1:0]  offset;
      logic [GLYPH_WIDTH-1:0] glyph;
      offset = code - FIRST_LETTER;
      glyph  = '0;
      if (code >= FIRST_LETTER && offset < CHAR_WIDTH'(LETTER_COUNT)) begin
         glyph = FONT_LOWER[offset[4:0]];
      end
      return glyph;
   endfunction

endpackage

@@ src/ssm_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module ssm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/ssm_front.sv @@
// Input stage: accepts transactions, holds the length register and the scroll position,
// and drives the message RAM ports. Depends on ssm_pkg.
module ssm_front #(
   parameter int MESSAGE_DEPTH = ssm_pkg::MESSAGE_DEPTH,
   localparam int ADDR_WIDTH = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  ssm_pkg::req_item_type                req_data,
   input  logic                                 csr_write_enable,
   input  logic [ssm_pkg::LENGTH_WIDTH-1:0]     csr_write_data,
   input  logic                                 exec_take,
   output ssm_pkg::stage_item_type              stage,
   output logic                                 ram_wr_en,
   output logic [ADDR_WIDTH-1:0]                ram_wr_addr,
   output logic [ssm_pkg::CHAR_WIDTH-1:0]       ram_wr_data,
   output logic                                 ram_rd_en,
   output logic [ADDR_WIDTH-1:0]                ram_rd_addr
);

   logic [ssm_pkg::LENGTH_WIDTH-1:0]   length_ff;
   logic [ssm_pkg::LENGTH_WIDTH-1:0]   length_sat;
   logic [ssm_pkg::POSITION_WIDTH-1:0] position_ff, position_in;
   logic [ssm_pkg::POSITION_WIDTH-1:0] position_eff;
   ssm_pkg::stage_item_type            stage_ff, stage_in;
   logic                               accept;
   logic                               is_scroll;
   logic                               index_ok;

   assign req_stall = stage_ff.valid && !exec_take;
   assign accept    = req_valid && !req_stall;
   assign is_scroll = (req_data.req_type == ssm_pkg::REQ_SCROLL);

   assign length_sat = (32'(length_ff) > MESSAGE_DEPTH) ?
                       ssm_pkg::LENGTH_WIDTH'(MESSAGE_DEPTH) : length_ff;

   // wrap once the two trailing blanks have gone by
   assign position_eff = (position_ff >= ssm_pkg::POSITION_WIDTH'(length_sat) + 8'd2) ?
                         '0 : position_ff;

   assign index_ok = (32'(req_data.write_index) < MESSAGE_DEPTH);

   assign ram_wr_en   = accept && (req_data.req_type == ssm_pkg::REQ_WRITE) && index_ok;
   assign ram_wr_addr = ADDR_WIDTH'(req_data.write_index);
   assign ram_wr_data = req_data.write_char;
   assign ram_rd_en   = accept && is_scroll;
   assign ram_rd_addr = ADDR_WIDTH'(position_eff);

   always_comb begin
      position_in = position_ff;
      stage_in    = stage_ff;
      if (accept) begin
         stage_in.valid    = 1'b1;
         stage_in.req_type = req_data.req_type;
         stage_in.in_range = position_eff < ssm_pkg::POSITION_WIDTH'(length_sat);
         if (is_scroll) begin
            position_in = position_eff + 8'd1;
         end
      end else if (exec_take) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff      <= '0;
         position_ff    <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            length_ff <= csr_write_data;
         end
         position_ff    <= position_in;
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.req_type <= stage_in.req_type;
      stage_ff.in_range <= stage_in.in_range;
   end

   assign stage = stage_ff;

endmodule

@@ src/ssm_exec.sv @@
// Execute stage: shifts the shown glyphs, scans the digits and registers the result.
// Depends on ssm_pkg; takes message bytes from the RAM read port.
module ssm_exec (
   input  logic                           clock,
   input  logic                           reset,
   input  ssm_pkg::stage_item_type        stage,
   input  logic [ssm_pkg::CHAR_WIDTH-1:0] ram_rd_data,
   output logic                           exec_take,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output ssm_pkg::rsp_item_type          rsp_data
);

   logic [ssm_pkg::GLYPH_WIDTH-1:0] glyph_ff [ssm_pkg::DIGIT_COUNT];
   logic [ssm_pkg::GLYPH_WIDTH-1:0] glyph_in [ssm_pkg::DIGIT_COUNT];
   logic [ssm_pkg::DIGIT_WIDTH-1:0] digit_ff, digit_in;
   logic [ssm_pkg::GLYPH_WIDTH-1:0] segment_ff, segment_in;
   logic [ssm_pkg::DIGIT_COUNT-1:0] enable_ff, enable_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   ssm_pkg::rsp_item_type           rsp_data_ff;
   logic                            fire;

   assign exec_take = !rsp_valid_ff || !rsp_stall;
   assign fire      = stage.valid && exec_take;

   always_comb begin
      glyph_in   = glyph_ff;
      digit_in   = digit_ff;
      segment_in = segment_ff;
      enable_in  = enable_ff;
      if (fire) begin
         unique case (stage.req_type)
            ssm_pkg::REQ_SCAN: begin
               segment_in = ~glyph_ff[digit_ff];
               enable_in  = ssm_pkg::DIGIT_COUNT'(1) << digit_ff;
               digit_in   = digit_ff + 2'd1;
            end
            ssm_pkg::REQ_SCROLL: begin
               for (int i = ssm_pkg::DIGIT_COUNT - 1; i > 0; i--) begin
                  glyph_in[i] = glyph_ff[i-1];
               end
               glyph_in[0] = stage.in_range ? ssm_pkg::glyph_of(ram_rd_data) : '0;
            end
            default: begin
               // writes went to the RAM at accept; unused codes change nothing
            end
         endcase
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ssm_pkg::DIGIT_COUNT; i++) begin
            glyph_ff[i] <= '0;
         end
         digit_ff     <= '0;
         segment_ff   <= '0;
         enable_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         glyph_ff     <= glyph_in;
         digit_ff     <= digit_in;
         segment_ff   <= segment_in;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fire) begin
         rsp_data_ff.segments_n   <= segment_in;
         rsp_data_ff.digit_enable <= enable_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ src/scrolling_seven_segment_mux.sv @@
// Scrolling seven-segment mux top level: input stage, message RAM, execute stage.
// Two register stages: the input stage register, then the result register.
// Throughput: one transaction per cycle while the result side does not stall.
// The RAM read for a scroll is issued at accept, so its registered data meets the execute stage.
// Reset (synchronous, active high) clears length, position, glyphs, drives and valid flags;
// the message RAM is not cleared, and a scroll reads it whether or not the position was written.
module scrolling_seven_segment_mux #(
   parameter int MESSAGE_DEPTH = ssm_pkg::MESSAGE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ssm_pkg::req_item_type            req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ssm_pkg::rsp_item_type            rsp_data,
   input  logic                             csr_write_enable,
   input  logic [ssm_pkg::LENGTH_WIDTH-1:0] csr_write_data
);

   localparam int ADDR_WIDTH = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;

   ssm_pkg::stage_item_type          stage;
   logic                             exec_take;
   logic                             ram_wr_en;
   logic [ADDR_WIDTH-1:0]            ram_wr_addr;
   logic [ssm_pkg::CHAR_WIDTH-1:0]   ram_wr_data;
   logic                             ram_rd_en;
   logic [ADDR_WIDTH-1:0]            ram_rd_addr;
   logic [ssm_pkg::CHAR_WIDTH-1:0]   ram_rd_data;

   ssm_front #(
      .MESSAGE_DEPTH(MESSAGE_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .exec_take       (exec_take),
      .stage           (stage),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr)
   );

   ssm_ram #(
      .WIDTH(ssm_pkg::CHAR_WIDTH),
      .DEPTH(MESSAGE_DEPTH)
   ) u_message_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   ssm_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .ram_rd_data(ram_rd_data),
      .exec_take  (exec_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

@@ src/ssm_checker.sv @@
// Port-level checks for the scrolling seven-segment mux, bound to the top level.
// Depends on ssm_pkg and on the top level's port list.
module ssm_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input ssm_pkg::rsp_item_type rsp_data
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   a_enable_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_data.digit_enable))
      else $error("digit enable not one-hot");

   // before the first scan both drives are still at reset
   a_blank_before_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.digit_enable == '0 |-> rsp_data.segments_n == '0)
      else $error("segments driven without a digit enable");

   // stall input only when the result side is full and blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while output free");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result valid right after reset");

endmodule

bind scrolling_seven_segment_mux ssm_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
